### src/key_event_defer_queue_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key event defer queue
// Shared property wrappers, all clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KEY_EVENT_DEFER_QUEUE_DEFINES_SVH
`define KEY_EVENT_DEFER_QUEUE_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define KEDQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds at the edge after the antecedent.
`define KEDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/kedq_pkg.sv
// ----------------------------------------------------------------------------
// Key event defer queue package
// Operation codes, the event word layout and the per-cell command group.
// ----------------------------------------------------------------------------
package kedq_pkg;

	localparam logic [2:0] FN_PUSH       = 3'd0;
	localparam logic [2:0] FN_POP        = 3'd1;
	localparam logic [2:0] FN_PEEK       = 3'd2;
	localparam logic [2:0] FN_QUERY      = 3'd3;
	localparam logic [2:0] FN_DISCARD    = 3'd4;
	localparam logic [2:0] FN_PROBE_POP  = 3'd5;
	localparam logic [2:0] FN_PROBE_PEEK = 3'd6;

	typedef struct packed {
		logic       press;
		logic [7:0] key_index;
	} event_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic load;   // write the key word into the cell at the given position
		logic shift;  // cells at or above the position take their neighbor's word
		logic scan;   // advance the read and match chains by one cell
	} cell_cmd_t;

endpackage

### src/key_event_defer_queue.sv
// ----------------------------------------------------------------------------
// Key event defer queue
// A queue of key events with a pop point and a peek point; events between
// the two are deferred. Push, pop, discard, both probes and the unused
// code finish at acceptance; peek and the deferred query run a result
// chain down a row of cells. One word moves one cell per cycle along the
// read and match chains; the sequencer scans until the result has reached
// cell zero, then writes it to the output register in its finish state.
// The row is kept compacted: cell i holds the i-th event after the pop
// point, so pop and discard shift the cells above the removed word down
// by one. Every operation returns exactly one result word, held in an
// output register; a new word is taken only while the sequencer is idle
// and that register is empty or being read. Nothing needs clearing after
// reset, since only cells below the fill count are ever read.
// ----------------------------------------------------------------------------
`include "key_event_defer_queue_defines.svh"

module key_event_defer_queue #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] func,
	input  logic [7:0] key_index,
	input  logic       key_press,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       ok,
	output logic [7:0] ev_key_index,
	output logic       ev_press
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	// Queue bookkeeping: total fill count and the size of the deferred span.
	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] dfr_q;
	logic [CW-1:0] scan_cnt_q;

	// The word under way during a scan.
	logic [2:0]       func_q;
	kedq_pkg::event_t key_q;

	// Output register.
	logic             out_valid_q;
	logic             ok_q;
	kedq_pkg::event_t ev_out_q;

	logic             in_accept;
	logic             out_take;
	logic             idle_accept;
	kedq_pkg::event_t in_ev;
	logic             full;
	logic             empty;
	logic             has_peek;
	logic             has_dfr;

	kedq_pkg::cell_cmd_t cmd;
	logic [CW-1:0]       pos;
	kedq_pkg::event_t    key_w;

	logic             res_set;
	logic             res_ok;
	kedq_pkg::event_t res_ev;

	kedq_pkg::event_t data_w [QUEUE_DEPTH];
	kedq_pkg::event_t bus_w  [QUEUE_DEPTH];
	logic             hit_w  [QUEUE_DEPTH];

	// A new word is taken only with the sequencer idle and room for its result.
	assign in_stall    = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_accept   = in_valid && !in_stall;
	assign out_take    = out_valid_q && !out_stall;
	assign idle_accept = in_accept && (state_q == ST_IDLE);

	assign in_ev.press     = key_press;
	assign in_ev.key_index = key_index;

	assign full     = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign has_peek = (dfr_q != cnt_q);
	assign has_dfr  = (dfr_q != '0);

	// Command for the row of cells. In the idle state the position is the
	// write slot for a push or the first cell that moves for pop and discard;
	// during a scan it is the peek position.
	always_comb begin
		cmd   = '0;
		pos   = cnt_q;
		key_w = in_ev;
		if (idle_accept) begin
			unique case (func)
				kedq_pkg::FN_PUSH: begin
					cmd.load = !full;
					pos      = cnt_q;
				end
				kedq_pkg::FN_POP: begin
					cmd.shift = !empty;
					pos       = '0;
				end
				kedq_pkg::FN_DISCARD: begin
					// The last deferred event sits just below the peek position.
					cmd.shift = has_dfr;
					pos       = dfr_q - 1'b1;
				end
				default: begin
					cmd = '0;
				end
			endcase
		end else if (state_q == ST_SCAN) begin
			cmd.scan = 1'b1;
			pos      = dfr_q;
			key_w    = key_q;
		end
	end

	// The row of cells. On a shift each cell at or above the position takes
	// its upper neighbor's word, and on a scan its upper neighbor's chain
	// stage; the top cell keeps its own word and sees an empty chain.
	for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
		kedq_pkg::event_t nxt_data;
		kedq_pkg::event_t nxt_bus;
		logic             nxt_hit;

		if (gi == QUEUE_DEPTH - 1) begin : g_top
			assign nxt_data = data_w[gi];
			assign nxt_bus  = '0;
			assign nxt_hit  = 1'b0;
		end else begin : g_mid
			assign nxt_data = data_w[gi+1];
			assign nxt_bus  = bus_w[gi+1];
			assign nxt_hit  = hit_w[gi+1];
		end

		kedq_cell #(
			.IDX_W(CW)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.idx      (CW'(gi)),
			.pos      (pos),
			.key      (key_w),
			.nxt_data (nxt_data),
			.nxt_bus  (nxt_bus),
			.nxt_hit  (nxt_hit),
			.data     (data_w[gi]),
			.bus      (bus_w[gi]),
			.hit      (hit_w[gi])
		);
	end

	// Result word. Single-cycle operations finish at acceptance; peek and
	// query finish once the chains have drained into cell zero.
	always_comb begin
		res_set = 1'b0;
		res_ok  = 1'b0;
		res_ev  = '0;
		if (idle_accept) begin
			unique case (func)
				kedq_pkg::FN_PUSH: begin
					res_set = 1'b1;
					res_ok  = !full;
				end
				kedq_pkg::FN_POP: begin
					res_set = 1'b1;
					res_ok  = !empty;
					res_ev  = empty ? '0 : data_w[0];
				end
				kedq_pkg::FN_DISCARD: begin
					res_set = 1'b1;
					res_ok  = has_dfr;
				end
				kedq_pkg::FN_PROBE_POP: begin
					res_set = 1'b1;
					res_ok  = !empty;
				end
				kedq_pkg::FN_PROBE_PEEK: begin
					res_set = 1'b1;
					res_ok  = has_peek;
				end
				kedq_pkg::FN_PEEK, kedq_pkg::FN_QUERY: begin
					res_set = 1'b0;
				end
				default: begin
					// The unused code answers with an all-zero word.
					res_set = 1'b1;
				end
			endcase
		end else if (state_q == ST_FIN) begin
			res_set = 1'b1;
			if (func_q == kedq_pkg::FN_PEEK) begin
				res_ok = has_peek;
				res_ev = has_peek ? bus_w[0] : '0;
			end else begin
				res_ok = hit_w[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			dfr_q       <= '0;
			scan_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						unique case (func)
							kedq_pkg::FN_PUSH: begin
								if (!full) begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							kedq_pkg::FN_POP: begin
								// Popping moves the peek point back to the new head.
								if (!empty) begin
									cnt_q <= cnt_q - 1'b1;
									dfr_q <= '0;
								end
							end
							kedq_pkg::FN_DISCARD: begin
								if (has_dfr) begin
									cnt_q <= cnt_q - 1'b1;
									dfr_q <= dfr_q - 1'b1;
								end
							end
							kedq_pkg::FN_PEEK, kedq_pkg::FN_QUERY: begin
								state_q    <= ST_SCAN;
								scan_cnt_q <= '0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (scan_cnt_q == CW'(QUEUE_DEPTH - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if ((func_q == kedq_pkg::FN_PEEK) && has_peek) begin
						dfr_q <= dfr_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (res_set) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (idle_accept) begin
			func_q <= func;
			key_q  <= in_ev;
		end
		if (res_set) begin
			ok_q     <= res_ok;
			ev_out_q <= res_ev;
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign ev_key_index = ev_out_q.key_index;
	assign ev_press     = ev_out_q.press;

	`KEDQ_ASSERT_ALWAYS(a_dfr_within_fill, dfr_q <= cnt_q, "deferred span exceeds fill count")
	`KEDQ_ASSERT_ALWAYS(a_fill_in_range, cnt_q <= CW'(QUEUE_DEPTH), "fill count exceeds depth")
	`KEDQ_ASSERT_NEXT(a_pop_resets_peek, idle_accept && (func == kedq_pkg::FN_POP) && !empty, dfr_q == '0, "pop left a deferred span")
	`KEDQ_ASSERT_NEXT(a_full_push_holds, idle_accept && (func == kedq_pkg::FN_PUSH) && full, $stable(cnt_q) && out_valid_q && !ok_q, "push into a full queue changed it")
	`KEDQ_ASSERT_NEXT(a_scan_result, (state_q == ST_FIN), (state_q == ST_IDLE) && out_valid_q, "scan finished without a result")

endmodule

### src/kedq_cell.sv
// ----------------------------------------------------------------------------
// Key event defer queue cell
// Holds one queue position and one stage of the read and match chains.
// ----------------------------------------------------------------------------
module kedq_cell #(
	parameter int IDX_W = 6
) (
	input  logic                clk,
	input  kedq_pkg::cell_cmd_t cmd,
	input  logic [IDX_W-1:0]    idx,
	input  logic [IDX_W-1:0]    pos,
	input  kedq_pkg::event_t    key,
	input  kedq_pkg::event_t    nxt_data,
	input  kedq_pkg::event_t    nxt_bus,
	input  logic                nxt_hit,
	output kedq_pkg::event_t    data,
	output kedq_pkg::event_t    bus,
	output logic                hit
);

	kedq_pkg::event_t data_q;
	kedq_pkg::event_t bus_q;
	logic             hit_q;
	logic             at_pos;
	logic             below_pos;

	assign at_pos    = (idx == pos);
	assign below_pos = (idx < pos);

	always_ff @(posedge clk) begin
		priority if (cmd.load && at_pos) begin
			data_q <= key;
		end else if (cmd.shift && !below_pos) begin
			data_q <= nxt_data;
		end else begin
			data_q <= data_q;
		end
		if (cmd.scan) begin
			bus_q <= at_pos ? data_q : nxt_bus;
			hit_q <= (below_pos && (data_q == key)) || nxt_hit;
		end
	end

	assign data = data_q;
	assign bus  = bus_q;
	assign hit  = hit_q;

endmodule

### sim/tb_key_event_defer_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the key event defer queue
// Sends a short directed run of key event operations and then about a
// thousand random ones, with random input gaps and output stalls. A ring
// buffer mirror of the queue predicts every reply word, and each reply is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_key_event_defer_queue;

	localparam int QDEPTH = 32;
	// Pointers count modulo twice the depth, so full and empty differ.
	localparam int PW = $clog2(2 * QDEPTH);
	// The one operation code that the package leaves unnamed; it does nothing.
	localparam logic [2:0] FN_UNUSED = 3'd7;
	localparam int RANDOM_OPS = 1000;
	localparam int MAX_REPORTS = 10;
	// The limit lies above the length of the whole run even if every word
	// took the slow scan path behind a long gap and a long stall.
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [2:0]       fn;
		kedq_pkg::event_t ev;
		bit               hold;  // wait until every reply is in before sending
	} key_op_t;

	typedef struct packed {
		logic             ok;
		kedq_pkg::event_t ev;
	} key_reply_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] func = kedq_pkg::FN_PUSH;
	logic [7:0] key_index = 8'd0;
	logic       key_press = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       ok;
	logic [7:0] ev_key_index;
	logic       ev_press;

	key_op_t    key_ops_pending[$];
	key_reply_t replies_due[$];

	// Mirror of the queue: a ring of events with pop, peek and push pointers.
	kedq_pkg::event_t mirror_store[QDEPTH];
	logic [PW-1:0]    mirror_head = '0;
	logic [PW-1:0]    mirror_peek = '0;
	logic [PW-1:0]    mirror_tail = '0;

	int cycle_cnt = 0;
	int mismatch_cnt = 0;
	int gap_left = 0;
	int stall_left = 0;

	key_event_defer_queue #(
		.QUEUE_DEPTH(QDEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.key_index(key_index),
		.key_press(key_press),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok(ok),
		.ev_key_index(ev_key_index),
		.ev_press(ev_press)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Number of events from one pointer up to another, modulo the pointer range.
	function automatic logic [PW-1:0] ring_span(logic [PW-1:0] from, logic [PW-1:0] to);
		return to - from;
	endfunction

	// Store slot of the event k places after pointer p.
	function automatic int ring_slot(logic [PW-1:0] p, int k);
		return (int'(p) + k) % QDEPTH;
	endfunction

	// Applies one operation to the mirror and returns the reply it must give.
	function automatic key_reply_t apply_key_op(logic [2:0] fn, kedq_pkg::event_t ev);
		key_reply_t r;
		int span;
		int k;
		r = '0;
		case (fn)
			kedq_pkg::FN_PUSH: begin
				if (ring_span(mirror_head, mirror_tail) < QDEPTH) begin
					mirror_store[ring_slot(mirror_tail, 0)] = ev;
					mirror_tail = mirror_tail + 1'b1;
					r.ok = 1'b1;
				end
			end
			kedq_pkg::FN_POP: begin
				// A pop also pulls the peek point back to the new head.
				if (mirror_head != mirror_tail) begin
					r.ev = mirror_store[ring_slot(mirror_head, 0)];
					mirror_head = mirror_head + 1'b1;
					mirror_peek = mirror_head;
					r.ok = 1'b1;
				end
			end
			kedq_pkg::FN_PEEK: begin
				if (mirror_peek != mirror_tail) begin
					r.ev = mirror_store[ring_slot(mirror_peek, 0)];
					mirror_peek = mirror_peek + 1'b1;
					r.ok = 1'b1;
				end
			end
			kedq_pkg::FN_QUERY: begin
				span = ring_span(mirror_head, mirror_peek);
				for (k = 0; k < span; k++) begin
					if (mirror_store[ring_slot(mirror_head, k)] == ev)
						r.ok = 1'b1;
				end
			end
			kedq_pkg::FN_DISCARD: begin
				// The newest deferred event goes; the older ones move up by one
				// slot and the head follows them.
				span = ring_span(mirror_head, mirror_peek);
				if (span != 0) begin
					for (k = span - 1; k >= 1; k--)
						mirror_store[ring_slot(mirror_head, k)] =
							mirror_store[ring_slot(mirror_head, k - 1)];
					mirror_head = mirror_head + 1'b1;
					r.ok = 1'b1;
				end
			end
			kedq_pkg::FN_PROBE_POP: r.ok = (mirror_head != mirror_tail);
			kedq_pkg::FN_PROBE_PEEK: r.ok = (mirror_peek != mirror_tail);
			default: ;
		endcase
		return r;
	endfunction

	// In one phase out of four neither side idles, so back-to-back words occur.
	function automatic bit calm_phase();
		return ((cycle_cnt / 2500) % 4) == 1;
	endfunction

	// Length of a gap or stall: mostly short, now and then long.
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		if (r < 92)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	// Keys come mostly from a small set so that deferred queries often match.
	function automatic logic [7:0] pick_key();
		if ($urandom_range(0, 9) < 7)
			return 8'($urandom_range(0, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_op(logic [2:0] fn, logic [7:0] key, logic press);
		key_op_t op;
		op.fn = fn;
		op.ev = {press, key};
		op.hold = 1'b0;
		key_ops_pending.push_back(op);
	endtask

	task automatic note_mismatch(string what, key_reply_t want);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("%0t: %s: expected ok=%0b key=%0d press=%0b, got ok=%0b key=%0d press=%0b",
				$time, what, want.ok, want.ev.key_index, want.ev.press,
				ok, ev_key_index, ev_press);
	endtask

	// Driver: presents the next pending word once the current one is taken,
	// and runs the mirror on every word that the block accepts.
	always @(posedge clk or negedge arst_n) begin : op_driver
		key_op_t op;
		key_reply_t reply;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				reply = apply_key_op(func, {key_press, key_index});
				replies_due.push_back(reply);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (key_ops_pending.size() == 0 ||
						(key_ops_pending[0].hold && replies_due.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					op = key_ops_pending.pop_front();
					in_valid <= 1'b1;
					func <= op.fn;
					key_index <= op.ev.key_index;
					key_press <= op.ev.press;
					gap_left <= (calm_phase() || $urandom_range(0, 1) == 0) ? 0 : pick_pause();
				end
			end
		end
	end

	// Monitor: checks each reply word taken and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin : reply_monitor
		key_reply_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid === 1'b1 && !out_stall) begin
				if (replies_due.size() == 0) begin
					note_mismatch("reply with none due", '0);
				end else begin
					want = replies_due.pop_front();
					if (ok !== want.ok || ev_key_index !== want.ev.key_index ||
							ev_press !== want.ev.press)
						note_mismatch("reply mismatch", want);
				end
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= 1'b0;
				if (!calm_phase() && $urandom_range(0, 3) == 0)
					stall_left <= pick_pause();
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_cnt);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int first_random;
		int seq_start;
		int len;
		int kind;

		// Every operation but push on the empty queue, and the unused code.
		add_op(kedq_pkg::FN_PROBE_POP, 8'd0, 1'b0);
		add_op(kedq_pkg::FN_PROBE_PEEK, 8'd255, 1'b1);
		add_op(kedq_pkg::FN_POP, 8'd255, 1'b1);
		add_op(kedq_pkg::FN_PEEK, 8'd0, 1'b0);
		add_op(kedq_pkg::FN_QUERY, 8'd0, 1'b0);
		add_op(kedq_pkg::FN_DISCARD, 8'd0, 1'b0);
		add_op(FN_UNUSED, 8'd255, 1'b1);
		// Four events, two of them peeked and so deferred.
		add_op(kedq_pkg::FN_PUSH, 8'd0, 1'b0);
		add_op(kedq_pkg::FN_PUSH, 8'd255, 1'b1);
		add_op(kedq_pkg::FN_PUSH, 8'hAA, 1'b1);
		add_op(kedq_pkg::FN_PUSH, 8'h55, 1'b0);
		add_op(kedq_pkg::FN_PEEK, 8'd0, 1'b0);
		add_op(kedq_pkg::FN_PEEK, 8'd0, 1'b0);
		// A match, a press bit mismatch and an event that is not yet deferred.
		add_op(kedq_pkg::FN_QUERY, 8'd255, 1'b1);
		add_op(kedq_pkg::FN_QUERY, 8'd255, 1'b0);
		add_op(kedq_pkg::FN_QUERY, 8'hAA, 1'b1);
		// Dropping the newest deferred event removes the match.
		add_op(kedq_pkg::FN_DISCARD, 8'd0, 1'b0);
		add_op(kedq_pkg::FN_QUERY, 8'd255, 1'b1);
		add_op(kedq_pkg::FN_PROBE_PEEK, 8'd0, 1'b0);
		// Pop resets the peek point, then drain to empty and one beyond.
		add_op(kedq_pkg::FN_POP, 8'd0, 1'b0);
		add_op(kedq_pkg::FN_PEEK, 8'd0, 1'b0);
		add_op(kedq_pkg::FN_POP, 8'd0, 1'b0);
		add_op(kedq_pkg::FN_POP, 8'd0, 1'b0);
		add_op(kedq_pkg::FN_POP, 8'd0, 1'b0);
		add_op(kedq_pkg::FN_PROBE_POP, 8'd0, 1'b0);

		// Fill to capacity and push once more while full. The sender first
		// waits for every reply so the fill starts from a quiet block.
		first_random = key_ops_pending.size();
		for (int i = 0; i < QDEPTH + 1; i++)
			add_op(kedq_pkg::FN_PUSH, pick_key(), 1'($urandom_range(0, 1)));
		key_ops_pending[first_random].hold = 1'b1;

		while (key_ops_pending.size() - first_random < RANDOM_OPS) begin
			seq_start = key_ops_pending.size();
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2: begin
					// Push bursts; a long one now and then runs into a full queue.
					len = ($urandom_range(0, 19) == 0) ? QDEPTH + 2 : $urandom_range(1, 6);
					repeat (len)
						add_op(kedq_pkg::FN_PUSH, pick_key(), 1'($urandom_range(0, 1)));
				end
				3: begin
					repeat ($urandom_range(1, 6))
						add_op(kedq_pkg::FN_PEEK, pick_key(), 1'($urandom_range(0, 1)));
					repeat (2)
						add_op(kedq_pkg::FN_QUERY, pick_key(), 1'($urandom_range(0, 1)));
				end
				4: begin
					repeat ($urandom_range(1, 4))
						add_op(kedq_pkg::FN_PEEK, pick_key(), 1'($urandom_range(0, 1)));
					repeat ($urandom_range(1, 3))
						add_op(kedq_pkg::FN_DISCARD, pick_key(), 1'($urandom_range(0, 1)));
					add_op(kedq_pkg::FN_QUERY, pick_key(), 1'($urandom_range(0, 1)));
				end
				5, 6: begin
					repeat ($urandom_range(1, 8))
						add_op(kedq_pkg::FN_POP, pick_key(), 1'($urandom_range(0, 1)));
				end
				7: begin
					repeat ($urandom_range(1, 4))
						add_op($urandom_range(0, 1) ? kedq_pkg::FN_PROBE_POP :
							kedq_pkg::FN_PROBE_PEEK, pick_key(), 1'($urandom_range(0, 1)));
				end
				default: begin
					// Noise: any code, the unused one included, with any key.
					repeat ($urandom_range(1, 5))
						add_op(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
				end
			endcase
			if ($urandom_range(0, 29) == 0)
				key_ops_pending[seq_start].hold = 1'b1;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (key_ops_pending.size() != 0 || in_valid || replies_due.size() != 0)
			@(posedge clk);
		// Let any stray reply word show up before the verdict.
		repeat (2 * QDEPTH + 8) @(posedge clk);

		if (mismatch_cnt == 0 && replies_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### key_event_defer_queue.f
+incdir+src
src/kedq_pkg.sv
src/kedq_cell.sv
src/key_event_defer_queue.sv
sim/tb_key_event_defer_queue.sv
